// ===== src/adaptive_mean_threshold_defines.svh =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: assertion macros
// Shared property wrappers for the port checker; clk and arst_n come from the
// scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_MEAN_THRESHOLD_DEFINES_SVH
`define ADAPTIVE_MEAN_THRESHOLD_DEFINES_SVH

// consequent holds in the same cycle
`define AMT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// consequent holds in the following cycle
`define AMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

// ===== src/amt_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: package
// Shared widths, register indexes, controller types and the reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 12;
	localparam int PIX_W     = 8;
	localparam int SUM_W     = 12;
	localparam int CNT_W     = 4;
	localparam int RCP_W     = 17;
	localparam int RCP_SHIFT = 16;
	localparam int PROD_W    = SUM_W + RCP_W;
	localparam int CFG_W     = 12;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MEAN_OFFSET  = 3'd2;
	localparam logic [IDX_W-1:0] REG_HIGH_VALUE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INVERT_MODE  = 3'd4;

	typedef logic [COL_W-1:0] amt_col_t;
	typedef logic [COL_W:0]   amt_wid_t;
	typedef logic [ROW_W-1:0] amt_row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_SUM,
		ST_MUL,
		ST_EMIT
	} amt_state_t;

	typedef struct packed {
		logic take;
		logic read;
		logic shift;
		logic sum;
		logic mul;
		logic emit;
		logic sel;
	} amt_cmd_t;

	typedef struct packed {
		logic item_ok;
		logic first_res;
		logic second_res;
		logic out_free;
	} amt_stat_t;

	// ceil(2^16 / n): exact floor division for sums below 2304
	function automatic logic [RCP_W-1:0] amt_recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		unique case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/amt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: controller
// Sequences read, window shift and up to two threshold decisions per request.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_ctrl import amt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire amt_stat_t stat,
	output      amt_cmd_t  cmd
);

	amt_state_t state_q, state_n;
	logic       sel_q, sel_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
		end
	end

	always_comb begin
		state_n = state_q;
		sel_n   = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.item_ok)
					state_n = ST_READ;
			end
			ST_READ:  state_n = ST_SHIFT;
			ST_SHIFT: begin
				sel_n = !stat.first_res;
				if (stat.first_res || stat.second_res)
					state_n = ST_SUM;
				else
					state_n = ST_IDLE;
			end
			ST_SUM:   state_n = ST_MUL;
			ST_MUL:   state_n = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) begin
					if (!sel_q && stat.second_res) begin
						sel_n   = 1'b1;
						state_n = ST_SUM;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = sel_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid && stat.item_ok;
			end
			ST_READ:  cmd.read  = 1'b1;
			ST_SHIFT: cmd.shift = 1'b1;
			ST_SUM:   cmd.sum   = 1'b1;
			ST_MUL:   cmd.mul   = 1'b1;
			ST_EMIT:  cmd.emit  = stat.out_free;
			default:  cmd       = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/amt_dpath.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: datapath
// Config registers, line stores, 3x3 window, masked sum, reciprocal multiply,
// threshold compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module amt_dpath import amt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_op,
	input  wire logic [PIX_W-1:0]     in_pix,
	input  wire amt_cmd_t             cmd,
	output      amt_stat_t            stat,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic [PIX_W-1:0]     out_value,
	output      logic                 out_row_end,
	output      logic                 out_image_end
);

	logic [10:0]       width_q;
	logic [11:0]       height_q;
	logic signed [8:0] offset_q;
	logic [PIX_W-1:0]  high_q;
	logic              invert_q;

	amt_col_t          col_q, c_q;
	amt_row_t          row_q, r_q;
	logic [PIX_W-1:0]  pix_q, top_q, mid_q;
	logic [PIX_W-1:0]  win_q [9];
	logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  lower_mem [MAX_WIDTH];

	logic [SUM_W-1:0]  sum_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic [PROD_W-1:0] prod_s2;

	logic              valid_q;
	logic [PIX_W-1:0]  value_q;
	logic              row_end_q, image_end_q;

	amt_wid_t          w_eff;
	amt_row_t          h_eff;
	amt_col_t          c_n;
	logic              phantom, last_col;
	logic [2:0]        rok, cok;
	logic [SUM_W-1:0]  sum_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [PIX_W-1:0]  mean, centre;
	logic signed [10:0] lhs, rhs;
	logic              above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 12'd480;
			offset_q <= '0;
			high_q   <= 8'd255;
			invert_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[11:0];
				REG_MEAN_OFFSET:  offset_q <= signed'(cfg_data[8:0]);
				REG_HIGH_VALUE:   high_q   <= cfg_data[7:0];
				REG_INVERT_MODE:  invert_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = amt_wid_t'(1);
		else if (int'(width_q) > MAX_WIDTH)
			w_eff = amt_wid_t'(MAX_WIDTH);
		else
			w_eff = amt_wid_t'(width_q);
		h_eff    = (height_q == '0) ? amt_row_t'(1) : height_q;
		phantom  = row_q >= h_eff;
		c_n      = (amt_wid_t'(col_q) >= w_eff) ? amt_col_t'(w_eff - 1'b1) : col_q;
		last_col = amt_wid_t'(c_q) == w_eff - 1'b1;
	end

	always_comb begin
		stat.item_ok    = !in_op || phantom;
		stat.first_res  = (r_q != '0) && (c_q != '0);
		stat.second_res = (r_q != '0) && last_col;
		stat.out_free   = !valid_q || out_ready;
	end

	// captured request and position
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			c_q   <= c_n;
			r_q   <= row_q;
			pix_q <= phantom ? '0 : in_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.shift) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (r_q >= h_eff) ? '0 : r_q + 1'b1;
			end else begin
				col_q <= c_q + 1'b1;
			end
		end
	end

	// line stores
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			top_q <= upper_mem[c_q];
			mid_q <= lower_mem[c_q];
		end
		if (cmd.shift) begin
			upper_mem[c_q] <= mid_q;
			lower_mem[c_q] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (cmd.shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[3*k]   <= win_q[3*k+1];
				win_q[3*k+1] <= win_q[3*k+2];
			end
			win_q[2] <= top_q;
			win_q[5] <= mid_q;
			win_q[8] <= pix_q;
		end
	end

	// neighbourhood masks; second result has its centre in window column 2
	always_comb begin
		rok[0] = (r_q >= 12'd2) && ((r_q - 12'd2) < h_eff);
		rok[1] = 1'b1;
		rok[2] = r_q < h_eff;
		if (cmd.sel) begin
			cok[0] = 1'b0;
			cok[1] = c_q != '0;
		end else begin
			cok[0] = c_q >= amt_col_t'(2);
			cok[1] = 1'b1;
		end
		cok[2] = 1'b1;
		sum_n  = '0;
		cnt_n  = '0;
		for (int i = 0; i < 9; i++) begin
			if (rok[i/3] && cok[i%3]) begin
				sum_n = sum_n + SUM_W'(win_q[i]);
				cnt_n = cnt_n + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_s1 <= sum_n;
			cnt_s1 <= cnt_n;
		end
		if (cmd.mul)
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(amt_recip(cnt_s1));
	end

	// centre > mean - offset  <=>  centre + offset > mean
	always_comb begin
		mean   = prod_s2[RCP_SHIFT +: PIX_W];
		centre = cmd.sel ? win_q[5] : win_q[4];
		lhs    = signed'({3'b000, centre}) + 11'(offset_q);
		rhs    = signed'({3'b000, mean});
		above  = lhs > rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q     <= (above != invert_q) ? high_q : '0;
			row_end_q   <= cmd.sel;
			image_end_q <= cmd.sel && (r_q == h_eff);
		end
	end

	assign out_valid     = valid_q;
	assign out_value     = value_q;
	assign out_row_end   = row_end_q;
	assign out_image_end = image_end_q;

endmodule

`default_nettype wire

// ===== src/adaptive_mean_threshold.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold
// 3x3 local-mean thresholding of a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// One request at a time. A pixel that completes no result passes the read and
// shift states before the next s_tready; one that completes a result then also
// passes the sum, multiply and emit states, and the last pixel of a row, which
// completes two, passes them twice; emit waits while m_tready holds off the
// output register. The sequence is set by the single-port line stores (read,
// then shift and write back) and by the shared sum, reciprocal multiply and
// compare unit. A drain request (s_tuser high) arriving before the phantom row
// is accepted and dropped without leaving the idle state. Results start after
// the first row; a row's last result carries tlast, the image's last result
// also tuser. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_mean_threshold import amt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	output      logic             s_tready,
	input  wire logic [7:0]       s_tdata,   // [7:0] grey_pixel
	input  wire logic             s_tuser,   // [0] op
	output      logic             m_tvalid,
	input  wire logic             m_tready,
	output      logic [7:0]       m_tdata,   // [7:0] result_value
	output      logic             m_tlast,   // row_end
	output      logic             m_tuser    // [0] image_end
);

	amt_cmd_t  cmd;
	amt_stat_t stat;

	amt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	amt_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_op         (s_tuser),
		.in_pix        (s_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_value     (m_tdata),
		.out_row_end   (m_tlast),
		.out_image_end (m_tuser)
	);

endmodule

`default_nettype wire

// ===== src/amt_checker.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: port checker
// Watches the top-level ports; bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_mean_threshold_defines.svh"

module amt_checker import amt_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             s_tuser,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [7:0]       m_tdata,
	input wire logic             m_tlast,
	input wire logic             m_tuser
);

	`AMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`AMT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
	`AMT_ASSERT_SAME(a_image_end_is_row_end, m_tvalid && m_tuser, m_tlast)
	`AMT_ASSERT_NEXT(a_pixel_busy, s_tvalid && s_tready && !s_tuser, !s_tready)

endmodule

bind adaptive_mean_threshold amt_checker u_amt_checker (.*);

`default_nettype wire

// ===== dv/adaptive_mean_threshold_test.sv =====
// ----------------------------------------------------------------------------
// Adaptive mean threshold: stream testbench
// Drives raster images of grey pixels and phantom-row drain requests through
// the block under random stalls on both buses, predicts every thresholded
// result from the 3x3 clipped local mean and checks the output stream in
// order. Register settings change only while the block is idle, including
// width and height shrinks part-way through an image.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold_test;
	timeunit 1ns;
	timeprecision 1ps;
	import amt_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int ITEM_TARGET   = 800;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_BOUND   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_PRINTS    = 30;

	localparam bit OP_PIXEL = 1'b0;
	localparam bit OP_DRAIN = 1'b1;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {TEX_NOISE, TEX_FLAT, TEX_BINARY, TEX_RAMP} texture_t;

	typedef struct packed {
		logic [7:0] value;
		logic       row_end;
		logic       image_end;
	} thr_result_t;

	class threshold_scoreboard;
		logic [7:0]  upper_line [MAX_WIDTH];
		logic [7:0]  lower_line [MAX_WIDTH];
		logic [7:0]  win [9];
		int unsigned col, row;
		int unsigned width_reg, height_reg;
		logic [8:0]  offset_reg;
		logic [7:0]  high_reg;
		bit          invert_reg;
		thr_result_t pending[$];
		int          errors, results_seen, items_taken, items_dropped;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (win[i])
				win[i] = '0;
			col = 0;
			row = 0;
			width_reg = 640;
			height_reg = 480;
			offset_reg = '0;
			high_reg = 8'd255;
			invert_reg = 1'b0;
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w < 1)
				w = 1;
			if (w > MAX_WIDTH)
				w = MAX_WIDTH;
			return w;
		endfunction

		function int unsigned eff_height();
			return (height_reg < 1) ? 1 : height_reg;
		endfunction

		// requests still needed to close the phantom row and return to the origin
		function int unsigned items_to_boundary();
			int unsigned w, h, c;
			w = eff_width();
			h = eff_height();
			c = (col >= w) ? w - 1 : col;
			if (row >= h)
				return w - c;
			return (h - row) * w - c + w;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = data[10:0];
				REG_IMAGE_HEIGHT: height_reg = data[11:0];
				REG_MEAN_OFFSET:  offset_reg = data[8:0];
				REG_HIGH_VALUE:   high_reg = data[7:0];
				REG_INVERT_MODE:  invert_reg = data[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] threshold_pixel(logic [2:0] rmask, logic [2:0] cmask,
				int unsigned ccol);
			int unsigned sum, count;
			int off, thr;
			sum = 0;
			count = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (rmask[i] && cmask[j]) begin
						sum += win[i * 3 + j];
						count++;
					end
			if (count == 0)
				count = 1;
			off = $signed(offset_reg);
			thr = int'(sum / count) - off;
			if ((int'(win[3 + ccol]) > thr) != invert_reg)
				return high_reg;
			return 8'd0;
		endfunction

		function void note_input(bit op, logic [7:0] pix);
			int unsigned w, h, c, r;
			logic [7:0]  top, mid, p;
			logic [2:0]  rmask, cmask;
			bit          phantom;
			thr_result_t res;
			w = eff_width();
			h = eff_height();
			r = row;
			phantom = r >= h;
			if (op && !phantom) begin
				items_dropped++;
				return;
			end
			items_taken++;
			p = phantom ? 8'd0 : pix;
			c = (col >= w) ? w - 1 : col;
			top = upper_line[c];
			mid = lower_line[c];
			for (int k = 0; k < 3; k++) begin
				win[k * 3]     = win[k * 3 + 1];
				win[k * 3 + 1] = win[k * 3 + 2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = p;
			upper_line[c] = mid;
			lower_line[c] = p;
			if (r >= 1) begin
				rmask[0] = (r >= 2) && (r - 2 < h);
				rmask[1] = 1'b1;
				rmask[2] = r < h;
				if (c >= 1) begin
					cmask = {1'b1, 1'b1, c >= 2};
					res.value = threshold_pixel(rmask, cmask, 1);
					res.row_end = 1'b0;
					res.image_end = 1'b0;
					pending = {pending, res};
				end
				if (c == w - 1) begin
					// centre sits in the right window column
					cmask = {1'b1, c >= 1, 1'b0};
					res.value = threshold_pixel(rmask, cmask, 2);
					res.row_end = 1'b1;
					res.image_end = (r - 1 == h - 1);
					pending = {pending, res};
				end
			end
			if (c + 1 >= w) begin
				col = 0;
				row = (r >= h) ? 0 : r + 1;
			end else begin
				col = c + 1;
			end
		endfunction

		function void flag(string field, int want, logic [7:0] got);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("%0t: result %0d %s expected %0h actual %0h",
					$time, results_seen, field, want, got);
		endfunction

		function void check_result(logic [7:0] value, logic row_end, logic image_end);
			thr_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: result %0d expected none actual %0h (tlast %b tuser %b)",
						$time, results_seen, value, row_end, image_end);
				return;
			end
			want = pending.pop_front();
			if (value !== want.value)
				flag("result_value", want.value, value);
			if (row_end !== want.row_end)
				flag("row_end", want.row_end, {7'd0, row_end});
			if (image_end !== want.image_end)
				flag("image_end", want.image_end, {7'd0, image_end});
		endfunction

		function void report_leftover();
			if (pending.size() != 0) begin
				errors += pending.size();
				$display("%0t: %0d results expected but never seen", $time, pending.size());
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	threshold_scoreboard sb;
	int       cycle_count;
	int       configs_used;
	bit       hold_req;
	bit       tx_burst;
	texture_t texture;
	int       tex_base;

	adaptive_mean_threshold u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: cycle limit reached", $time);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result receiver: random stalls, quiet stretches and one long hold-off
	initial begin : receiver
		int stall;
		int phase_left;
		bit rx_burst;
		m_tready = 1'b0;
		stall = 0;
		rx_burst = 1'b0;
		phase_left = $urandom_range(50, 300);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
				if (!rx_burst && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
			if (--phase_left == 0) begin
				rx_burst = ~rx_burst;
				phase_left = $urandom_range(50, 300);
			end
		end
	end

	always @(posedge clk)
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata, m_tlast, m_tuser);

	task automatic push_item(bit op, logic [7:0] pix);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = pix;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_input(op, pix);
	endtask

	// wait for the block to go idle: all results in, then its internal latency
	task automatic settle();
		int waited;
		@(negedge clk);
		s_tvalid = 1'b0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < DRAIN_BOUND) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(int w, int h, int off, int hv, bit inv);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		write_reg(REG_MEAN_OFFSET, CFG_W'(off & 'h1FF));
		write_reg(REG_HIGH_VALUE, CFG_W'(hv));
		write_reg(REG_INVERT_MODE, CFG_W'(inv));
		configs_used++;
	endtask

	function automatic logic [7:0] next_pixel();
		int v;
		case (texture)
			TEX_FLAT: begin
				v = tex_base + int'($urandom_range(0, 4)) - 2;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return 8'(v);
			end
			TEX_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			TEX_RAMP:   return 8'(tex_base + sb.col * 17 + sb.row * 5);
			default:    return 8'($urandom);
		endcase
	endfunction

	// n position-advancing requests; early drains are mixed in while rows are real
	task automatic send_span(int n);
		int done;
		done = 0;
		while (done < n) begin
			if (sb.row < sb.eff_height() && $urandom_range(0, 29) == 0) begin
				push_item(OP_DRAIN, 8'($urandom));
			end else if (sb.row >= sb.eff_height()) begin
				push_item($urandom_range(0, 1), 8'($urandom));
				done++;
			end else begin
				push_item(OP_PIXEL, next_pixel());
				done++;
			end
		end
	endtask

	task automatic send_to_boundary();
		send_span(sb.items_to_boundary());
	endtask

	function automatic int rand_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 70)
			return $urandom_range(1, 8);
		return $urandom_range(9, 24);
	endfunction

	function automatic int rand_height();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		return $urandom_range(5, 8);
	endfunction

	function automatic int rand_offset();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return int'($urandom_range(0, 12)) - 6;
		if (r < 8)
			return int'($urandom_range(0, 510)) - 255;
		if (r == 8)
			return $urandom_range(0, 1) ? 255 : -255;
		return 0;
	endfunction

	function automatic int rand_high();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 255;
		if (r == 4)
			return 0;
		return $urandom_range(0, 255);
	endfunction

	task automatic pick_texture();
		texture = texture_t'($urandom_range(0, 3));
		tex_base = $urandom_range(0, 255);
	endtask

	// stop part-way, let the block go idle, change one register, then finish
	task automatic mid_image_change();
		int rem;
		rem = sb.items_to_boundary();
		if (rem >= 2)
			send_span($urandom_range(1, rem - 1));
		settle();
		case ($urandom_range(0, 3))
			0: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, sb.eff_width())));
			1: write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, sb.eff_height() + 2)));
			2: write_reg(REG_MEAN_OFFSET, CFG_W'(rand_offset() & 'h1FF));
			default: write_reg(REG_INVERT_MODE, CFG_W'($urandom_range(0, 1)));
		endcase
		send_to_boundary();
	endtask

	initial begin
		bit hold_done;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		hold_req = 1'b0;
		tx_burst = 1'b0;
		hold_done = 1'b0;
		configs_used = 0;
		texture = TEX_NOISE;
		tex_base = 0;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// single column, early drain, late pixel in the phantom row
		set_config(1, 3, 0, 255, 1'b0);
		write_reg(REG_UNUSED, 12'hFFF);
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd128);
		push_item(OP_PIXEL, 8'd255);
		settle();

		// checkerboard, offset -255, inverted
		set_config(4, 2, -255, 255, 1'b1);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'd77);
		push_item(OP_DRAIN, 8'hAA);
		push_item(OP_DRAIN, 8'h55);
		settle();

		// most positive offset, odd high value
		set_config(2, 2, 255, 8'h5A, 1'b0);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		settle();

		// largest width and height values, then width shrunk mid-row, height shrunk mid-image
		pick_texture();
		set_config(2047, 4095, rand_offset(), rand_high(), $urandom_range(0, 1));
		send_span(30);
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(6));
		send_span(15);
		settle();
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_to_boundary();

		while (sb.items_taken < ITEM_TARGET) begin
			pick_texture();
			tx_burst = ($urandom_range(0, 3) == 0);
			if (!hold_done && sb.items_taken > 300) begin
				// receiver stops for a long stretch while requests keep coming
				settle();
				set_config(12, 4, rand_offset(), rand_high(), $urandom_range(0, 1));
				hold_done = 1'b1;
				tx_burst = 1'b1;
				hold_req = 1'b1;
				send_to_boundary();
			end else begin
				if ($urandom_range(0, 9) < 7) begin
					settle();
					set_config(rand_width(), rand_height(), rand_offset(), rand_high(),
						$urandom_range(0, 1));
				end
				if ($urandom_range(0, 4) == 0)
					mid_image_change();
				else
					send_to_boundary();
			end
		end

		settle();
		sb.report_leftover();
		$display("Covered %0d position requests, %0d dropped early drains, %0d results",
			sb.items_taken, sb.items_dropped, sb.results_seen);
		$display("over %0d register settings; %0d failures.", configs_used, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
